// ----- rtl/bmpr_pkg.sv -----
// bmpr_pkg: shared types and constants for the bmp rle8 decoder
// parse phases, escape codes and the result record passed to the output buffer
// no dependencies
package bmpr_pkg;

    localparam int CodeW  = 8;
    localparam int WidthW = 16;
    localparam int CountW = 24;

    localparam logic [CodeW-1:0] EscEndOfLine   = 8'd0;
    localparam logic [CodeW-1:0] EscEndOfBitmap = 8'd1;
    localparam logic [CodeW-1:0] EscDelta       = 8'd2;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_VALUE   = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_DX      = 3'd3,
        PH_DY      = 3'd4,
        PH_LITERAL = 3'd5,
        PH_PAD     = 3'd6
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [CodeW-1:0]  value;
        logic [CountW-1:0] count;
        logic              eoi;
    } run_rec_t;

endpackage

// ----- rtl/bmpr_parser.sv -----
// bmpr_parser: rle8 parse state machine, one code byte per accepted item
// produces at most one result per item; uses bmpr_pkg
module bmpr_parser
    import bmpr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [CodeW-1:0]  code_byte,
    input  logic [WidthW-1:0] image_width,
    output run_rec_t          res
);

    phase_t            phase_reg, phase_next;
    logic [CodeW-1:0]  held_count_reg, held_count_next;
    logic [CodeW-1:0]  held_dx_reg, held_dx_next;
    logic              pad_pending_reg, pad_pending_next;
    logic              image_done_reg, image_done_next;
    logic [CodeW-1:0]  count_dec;
    logic [CountW-1:0] delta_total;

    assign count_dec   = held_count_reg - 8'd1;
    assign delta_total = CountW'(held_dx_reg) + CountW'(image_width) * CountW'(code_byte);

    // next state
    always_comb begin
        phase_next       = phase_reg;
        held_count_next  = held_count_reg;
        held_dx_next     = held_dx_reg;
        pad_pending_next = pad_pending_reg;
        image_done_next  = image_done_reg;
        if (accept && !image_done_reg) begin
            unique case (phase_reg)
                PH_VALUE: begin
                    phase_next = PH_FIRST;
                end
                PH_ESCAPE: begin
                    if (code_byte == EscEndOfLine) begin
                        phase_next = PH_FIRST;
                    end else if (code_byte == EscEndOfBitmap) begin
                        phase_next      = PH_FIRST;
                        image_done_next = 1'b1;
                    end else if (code_byte == EscDelta) begin
                        phase_next = PH_DX;
                    end else begin
                        held_count_next  = code_byte;
                        pad_pending_next = code_byte[0];
                        phase_next       = PH_LITERAL;
                    end
                end
                PH_DX: begin
                    held_dx_next = code_byte;
                    phase_next   = PH_DY;
                end
                PH_DY: begin
                    phase_next = PH_FIRST;
                end
                PH_LITERAL: begin
                    held_count_next = count_dec;
                    if (count_dec == '0) begin
                        phase_next = pad_pending_reg ? PH_PAD : PH_FIRST;
                    end
                end
                PH_PAD: begin
                    pad_pending_next = 1'b0;
                    phase_next       = PH_FIRST;
                end
                default: begin
                    if (code_byte == '0) begin
                        phase_next = PH_ESCAPE;
                    end else begin
                        held_count_next = code_byte;
                        phase_next      = PH_VALUE;
                    end
                end
            endcase
        end
    end

    // result for the item being accepted
    always_comb begin
        res = '0;
        if (accept && !image_done_reg) begin
            unique case (phase_reg)
                PH_VALUE: begin
                    res.valid = 1'b1;
                    res.value = code_byte;
                    res.count = CountW'(held_count_reg);
                end
                PH_ESCAPE: begin
                    if (code_byte == EscEndOfBitmap) begin
                        res.valid = 1'b1;
                        res.eoi   = 1'b1;
                    end
                end
                PH_DY: begin
                    // an empty delta gives no result
                    res.valid = (delta_total != '0);
                    res.count = delta_total;
                end
                PH_LITERAL: begin
                    res.valid = 1'b1;
                    res.value = code_byte;
                    res.count = CountW'(1);
                end
                default: begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_FIRST;
            held_count_reg  <= '0;
            held_dx_reg     <= '0;
            pad_pending_reg <= 1'b0;
            image_done_reg  <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            held_count_reg  <= held_count_next;
            held_dx_reg     <= held_dx_next;
            pad_pending_reg <= pad_pending_next;
            image_done_reg  <= image_done_next;
        end
    end

    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        image_done_reg |-> !res.valid)
        else $error("result produced after end of image");

    a_literal_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LITERAL) |-> (held_count_reg != '0))
        else $error("literal phase with zero count");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res.eoi) |-> (res.count != '0))
        else $error("run result with zero length");

endmodule

// ----- rtl/bmpr_out_buf.sv -----
// bmpr_out_buf: two-entry result queue between parser and the master channel
// lets the input side keep accepting while one result waits; uses bmpr_pkg
module bmpr_out_buf
    import bmpr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  run_rec_t          wr_res,
    output logic              full,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CodeW-1:0]  m_value,
    output logic [CountW-1:0] m_count,
    output logic              m_eoi
);

    run_rec_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       wr_en, rd_en;

    assign wr_en   = wr_res.valid;
    assign m_valid = (fill_reg != 2'd0);
    assign rd_en   = m_valid && m_ready;
    assign full    = (fill_reg == 2'd2);
    assign m_value = entry_reg[rd_ptr_reg].value;
    assign m_count = entry_reg[rd_ptr_reg].count;
    assign m_eoi   = entry_reg[rd_ptr_reg].eoi;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        fill_next   = fill_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("result queue overfilled");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !wr_en)
        else $error("result written into a full queue");

    a_write_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd0 && wr_en) |=> m_valid)
        else $error("written result not presented");

endmodule

// ----- rtl/bmp_rle8_decoder_unit.sv -----
// bmp_rle8_decoder_unit: top level of the bmp rle8 stream decoder
// holds the apb width register; uses bmpr_pkg, bmpr_parser, bmpr_out_buf
//
// usage:
//   s_axis: one compressed rle8 byte per item in s_tdata.
//   m_axis: one pixel run per item; m_tdata = {repeat_count, pixel_value},
//   m_tuser = end_of_image. delta escapes give a zero-value run, the end of
//   bitmap escape gives value 0, count 0 with end_of_image set.
//   apb: register 0 at byte address 0 is image_width (16 bits, reset 1);
//   write only while the block is idle.
// timing:
//   one byte accepted per cycle while the result queue is not full; each
//   result enters the queue at the accept edge of its byte. bytes that
//   produce nothing (count, escape, pad, anything after end of image)
//   leave no result. the parse state machine updates at the accept edge
//   and the 16x8 delta product feeds straight into a two-entry result queue.
// reset and stall:
//   aresetn (synchronous, active low) returns to the start of a pair, clears
//   the end-of-image flag and empties the queue. when m_tready is low the
//   queue holds up to two results; s_tready drops only while it is full.
module bmp_rle8_decoder_unit
    import bmpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [7:0] code_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: [7:0] pixel_value, [31:8] repeat_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // m_tuser: [0] end_of_image
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [WidthW-1:0] image_width_reg;
    logic              accept;
    logic              q_full;
    run_rec_t          res;
    logic [CodeW-1:0]  out_value;
    logic [CountW-1:0] out_count;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {16'd0, image_width_reg} : 32'd0;
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = {out_count, out_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= WidthW'(1);
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            image_width_reg <= pwdata[WidthW-1:0];
        end
    end

    bmpr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .code_byte   (s_tdata),
        .image_width (image_width_reg),
        .res         (res)
    );

    bmpr_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_res  (res),
        .full    (q_full),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_value (out_value),
        .m_count (out_count),
        .m_eoi   (m_tuser)
    );

endmodule

// ----- test/tb_bmp_rle8_decoder_unit.sv -----
// tb_bmp_rle8_decoder_unit: self-checking testbench for the bmp rle8 stream decoder
// drives compressed bytes, apb width writes and result back-pressure; predicts each run
// depends on bmpr_pkg and bmp_rle8_decoder_unit
module tb_bmp_rle8_decoder_unit;
    import bmpr_pkg::*;

    localparam logic [2:0] WidthAddr = 3'd0;
    localparam int LongHoldCycles   = 400;
    localparam int SettleCycles     = 8;
    localparam int DrainCycles      = 20;
    localparam int PhaseItems       = 175;

    typedef struct packed {
        logic [7:0]  value;
        logic [23:0] count;
        logic        eoi;
    } pixel_run_t;

    // tracks the parse state of the stream and the runs it must produce
    class rle8_run_tracker;
        phase_t      phase;
        logic [7:0]  held_count;
        logic [7:0]  held_dx;
        logic        pad_pending;
        logic        image_done;
        logic [15:0] width;
        pixel_run_t  runs_due[$];
        int          errors;
        int          checked;
        int          deltas;
        int          literals;

        function new();
            phase       = PH_FIRST;
            held_count  = 8'd0;
            held_dx     = 8'd0;
            pad_pending = 1'b0;
            image_done  = 1'b0;
            width       = 16'd1;
            errors      = 0;
            checked     = 0;
            deltas      = 0;
            literals    = 0;
        endfunction

        function void push_run(logic [7:0] value, logic [23:0] count, logic eoi);
            pixel_run_t r;
            r.value = value;
            r.count = count;
            r.eoi   = eoi;
            runs_due.push_back(r);
        endfunction

        function void decode_byte(logic [7:0] b);
            logic [31:0] total;
            if (image_done) return;
            case (phase)
                PH_VALUE: begin
                    phase = PH_FIRST;
                    push_run(b, {16'd0, held_count}, 1'b0);
                end
                PH_ESCAPE: begin
                    if (b == EscEndOfLine) begin
                        phase = PH_FIRST;
                    end else if (b == EscEndOfBitmap) begin
                        phase      = PH_FIRST;
                        image_done = 1'b1;
                        push_run(8'd0, 24'd0, 1'b1);
                    end else if (b == EscDelta) begin
                        phase = PH_DX;
                    end else begin
                        held_count  = b;
                        pad_pending = b[0];
                        phase       = PH_LITERAL;
                    end
                end
                PH_DX: begin
                    held_dx = b;
                    phase   = PH_DY;
                end
                PH_DY: begin
                    phase = PH_FIRST;
                    total = {24'd0, held_dx} + {16'd0, width} * {24'd0, b};
                    // an empty delta leaves no run behind
                    if (total != 32'd0) begin
                        deltas++;
                        push_run(8'd0, total[23:0], 1'b0);
                    end
                end
                PH_LITERAL: begin
                    held_count = held_count - 8'd1;
                    if (held_count == 8'd0)
                        phase = pad_pending ? PH_PAD : PH_FIRST;
                    literals++;
                    push_run(b, 24'd1, 1'b0);
                end
                PH_PAD: begin
                    pad_pending = 1'b0;
                    phase       = PH_FIRST;
                end
                default: begin
                    if (b == 8'd0) begin
                        phase = PH_ESCAPE;
                    end else begin
                        held_count = b;
                        phase      = PH_VALUE;
                    end
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= 20) $display("mismatch: %s", what);
        endtask

        task check_run(logic [31:0] tdata, logic tuser);
            pixel_run_t want;
            if (runs_due.size() == 0) begin
                report($sformatf("unexpected run value %0d count %0d eoi %0b",
                                 tdata[7:0], tdata[31:8], tuser));
                return;
            end
            want = runs_due.pop_front();
            checked++;
            if (tdata[7:0] !== want.value)
                report($sformatf("run %0d pixel_value %0d, want %0d",
                                 checked, tdata[7:0], want.value));
            if (tdata[31:8] !== want.count)
                report($sformatf("run %0d repeat_count %0d, want %0d",
                                 checked, tdata[31:8], want.count));
            if (tuser !== want.eoi)
                report($sformatf("run %0d end_of_image %0b, want %0b",
                                 checked, tuser, want.eoi));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    rle8_run_tracker tracker;
    bit calm;
    bit hold_request;
    bit end_allowed;
    int items_sent;
    int in_stalls;
    int width_writes;

    bmp_rle8_decoder_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_run(m_tdata, m_tuser);
        if (aresetn && s_tvalid && !s_tready) in_stalls++;
    end

    initial begin : result_sink
        int stall;
        stall = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LongHoldCycles) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (!calm && $urandom_range(0, 99) < 15) begin
                m_tready <= 1'b0;
                stall = pick_gap();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        // keep the bitmap open until the closing phase
        if (!end_allowed && tracker.phase == PH_ESCAPE && b == EscEndOfBitmap)
            b = EscEndOfLine;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        tracker.decode_byte(b);
    endtask

    task automatic send_run(input logic [7:0] count, input logic [7:0] value);
        send_byte(count);
        send_byte(value);
    endtask

    task automatic send_delta(input logic [7:0] dx, input logic [7:0] dy);
        send_byte(8'd0);
        send_byte(EscDelta);
        send_byte(dx);
        send_byte(dy);
    endtask

    task automatic send_absolute(input int n);
        send_byte(8'd0);
        send_byte(n[7:0]);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
        if (n % 2 == 1) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_command();
        int pick;
        int r;
        logic [7:0] dy;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_run(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
        end else if (pick < 65) begin
            if ($urandom_range(0, 19) == 0) send_absolute($urandom_range(128, 255));
            else send_absolute($urandom_range(3, 12));
        end else if (pick < 77) begin
            r = $urandom_range(0, 9);
            if (r < 5) dy = 8'd0;
            else if (r < 8) dy = 8'($urandom_range(1, 3));
            else dy = 8'($urandom_range(0, 255));
            send_delta(8'($urandom_range(0, 255)), dy);
        end else if (pick < 86) begin
            send_byte(8'd0);
            send_byte(EscEndOfLine);
        end else begin
            // stray byte, shifts the parser out of step
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // end-of-line escapes walk any parse phase back to the start of a pair
    task automatic realign();
        while (tracker.phase != PH_FIRST) send_byte(EscEndOfLine);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.runs_due.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_width(input logic [15:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WidthAddr;
        pwdata  <= {16'd0, w};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.width = w;
        width_writes++;
    endtask

    task automatic check_width_readback();
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WidthAddr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {16'd0, tracker.width})
            tracker.report($sformatf("image_width reads %0h, want %0h", rd, tracker.width));
    endtask

    initial begin : stimulus
        logic [15:0] widths [8];
        tracker = new();
        widths = '{16'd65535, 16'd0, 16'd1, 16'd0, 16'd640, 16'd0, 16'd65535, 16'd3};
        widths[3] = 16'($urandom_range(1, 65535));
        widths[5] = 16'($urandom_range(2, 16));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_width_readback();

        // directed: count extremes, end of line, deltas, absolute with and without pad
        send_run(8'd255, 8'd0);
        send_run(8'd1, 8'd255);
        send_byte(8'd0);
        send_byte(EscEndOfLine);
        send_delta(8'd255, 8'd255);
        send_delta(8'd0, 8'd0);
        send_absolute(3);
        send_absolute(4);

        for (int p = 0; p < 8; p++) begin
            settle();
            write_width(widths[p]);
            check_width_readback();
            calm = (p == 4);
            realign();
            send_delta(8'd255, 8'd255);
            if (p == 1) begin
                // results back up behind a long receiver stall
                calm = 1'b1;
                hold_request = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_run(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
                calm = 1'b0;
            end
            if (p == 5) send_absolute(255);
            while (items_sent < 26 + PhaseItems * (p + 1)) send_command();
        end

        // close the bitmap; the bytes after it must leave nothing
        calm = 1'b0;
        realign();
        end_allowed = 1'b1;
        send_byte(8'd0);
        send_byte(EscEndOfBitmap);
        for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        while (tracker.runs_due.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("covered %0d bytes across %0d width settings; %0d runs checked",
                 items_sent, width_writes + 1, tracker.checked);
        $display("%0d deltas and %0d literal runs; input stalled %0d cycles by back-pressure",
                 tracker.deltas, tracker.literals, in_stalls);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bmpr_pkg.sv
rtl/bmpr_parser.sv
rtl/bmpr_out_buf.sv
rtl/bmp_rle8_decoder_unit.sv
test/tb_bmp_rle8_decoder_unit.sv
